// ===== src/packet_checksum_classifier_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet checksum classifier
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PACKET_CHECKSUM_CLASSIFIER_UNIT_MACROS_SVH
`define PACKET_CHECKSUM_CLASSIFIER_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pcc assertion failed");
// next-cycle implication
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet checksum classifier package
// Shared constants and the result kind encoding.
// ----------------------------------------------------------------------------
package pcc_pkg;

	localparam int COUNT_W          = 8;
	localparam int SUM_W            = 32;
	localparam int SUM_BYTES        = 20;
	localparam int RECORD_BYTES     = 24;
	localparam int CONTROL_LIMIT    = 32;
	localparam int MAX_PACKET_BYTES = 250;

	typedef enum logic [2:0] {
		KIND_OK       = 3'd0,
		KIND_MISSING  = 3'd1,
		KIND_MISMATCH = 3'd2,
		KIND_TEXT     = 3'd3,
		KIND_BINARY   = 3'd4
	} kind_t;

endpackage

// ===== src/pcc_byte_if.sv =====
// ----------------------------------------------------------------------------
// Packet byte channel
// valid/ready handshake carrying one packet byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface pcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/pcc_result_if.sv =====
// ----------------------------------------------------------------------------
// Packet result channel
// valid/ready handshake carrying one classification word per packet.
// ----------------------------------------------------------------------------
interface pcc_result_if;
	import pcc_pkg::*;

	logic         valid;
	logic         ready;
	kind_t        kind;
	logic [31:0]  computed_sum;
	logic [31:0]  received_sum;
	logic [7:0]   packet_length;

	modport source (output valid, output kind, output computed_sum, output received_sum,
		output packet_length, input ready);
	modport sink   (input valid, input kind, input computed_sum, input received_sum,
		input packet_length, output ready);
endinterface

// ===== src/packet_checksum_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// Packet checksum classifier. Throughput one byte word per cycle unless a last byte
// awaits a full result slot; the next packet may follow back to back.
// Stage 1 registers the byte, stage 2 updates packet state and the result.
// Async reset clears all packet state and both valid flags.
// ----------------------------------------------------------------------------
module packet_checksum_classifier_unit #(
	parameter int MAX_PACKET_BYTES = pcc_pkg::MAX_PACKET_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	pcc_byte_if.sink            bytes,
	pcc_result_if.source        results
);
	import pcc_pkg::*;

	// stage 1: input register
	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              last_s1;

	// packet state
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   cap_q;
	logic               ctrl_q;

	// result register
	logic               out_valid_q;
	kind_t              kind_q;
	logic [SUM_W-1:0]   csum_q;
	logic [SUM_W-1:0]   rsum_q;
	logic [COUNT_W-1:0] len_q;

	// next-state terms
	logic               adv_s1;
	logic               out_free;
	logic [SUM_W-1:0]   xored;
	logic [SUM_W-1:0]   sum_next;
	logic [SUM_W-1:0]   cap_next;
	logic               ctrl_next;
	logic [COUNT_W-1:0] count_next;
	logic [COUNT_W-1:0] cap_off;
	logic               is_record;
	kind_t              kind_next;
	logic [SUM_W-1:0]   csum_next;
	logic [SUM_W-1:0]   rsum_next;

	// The result slot is free if empty or being drained this cycle. Only a
	// last byte needs it; all other bytes move on unconditionally.
	assign out_free     = !out_valid_q || results.ready;
	assign adv_s1       = valid_s1 && (!last_s1 || out_free);
	assign bytes.ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			data_s1 <= bytes.data_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	// Per-byte update: xor + rotate for the checksum window, byte lane write
	// for the received checksum window, control-byte flag, saturating count.
	assign cap_off = count_q - COUNT_W'(SUM_BYTES);
	assign xored   = sum_q ^ {{(SUM_W-8){1'b0}}, data_s1};

	always_comb begin
		sum_next = sum_q;
		cap_next = cap_q;
		if (count_q < COUNT_W'(SUM_BYTES)) begin
			sum_next = {xored[SUM_W-2:0], xored[SUM_W-1]};
		end else if (count_q < COUNT_W'(RECORD_BYTES)) begin
			cap_next[{cap_off[1:0], 3'b000} +: 8] = data_s1;
		end
	end

	assign ctrl_next  = ctrl_q || ((data_s1 != 8'd0) && (data_s1 < 8'(CONTROL_LIMIT)));
	assign count_next = (count_q < COUNT_W'(MAX_PACKET_BYTES)) ? count_q + COUNT_W'(1)
		: count_q;

	// Classification on the final byte. Only an exact record length carries
	// the sums; text and binary report them as zero.
	assign is_record = (count_next == COUNT_W'(RECORD_BYTES));

	always_comb begin
		csum_next = '0;
		rsum_next = '0;
		if (is_record) begin
			csum_next = sum_next;
			rsum_next = cap_next;
			if (cap_next == '0) begin
				kind_next = KIND_MISSING;
			end else if (cap_next != sum_next) begin
				kind_next = KIND_MISMATCH;
			end else begin
				kind_next = KIND_OK;
			end
		end else if (ctrl_next) begin
			kind_next = KIND_BINARY;
		end else begin
			kind_next = KIND_TEXT;
		end
	end

	// packet state: cleared after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			cap_q   <= '0;
			ctrl_q  <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				count_q <= '0;
				sum_q   <= '0;
				cap_q   <= '0;
				ctrl_q  <= 1'b0;
			end else begin
				count_q <= count_next;
				sum_q   <= sum_next;
				cap_q   <= cap_next;
				ctrl_q  <= ctrl_next;
			end
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			kind_q <= kind_next;
			csum_q <= csum_next;
			rsum_q <= rsum_next;
			len_q  <= count_next;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.kind          = kind_q;
	assign results.computed_sum  = csum_q;
	assign results.received_sum  = rsum_q;
	assign results.packet_length = len_q;

	// ------------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------------
`include "packet_checksum_classifier_unit_macros.svh"

	// record kinds only come from an exact record length
	`PCC_ASSERT_IMPL(a_record_len, clk, arst_n, out_valid_q && (kind_q == KIND_OK || kind_q == KIND_MISSING || kind_q == KIND_MISMATCH), len_q == COUNT_W'(RECORD_BYTES))
	// text and binary words carry zero sums
	`PCC_ASSERT_IMPL(a_nonrecord_sums, clk, arst_n, out_valid_q && (kind_q == KIND_TEXT || kind_q == KIND_BINARY), csum_q == '0 && rsum_q == '0)
	// state is cleared once a final byte is consumed
	`PCC_ASSERT_NEXT(a_state_clear, clk, arst_n, adv_s1 && last_s1, count_q == '0 && sum_q == '0 && cap_q == '0 && !ctrl_q)
	// byte count never passes the saturation limit
	`PCC_ASSERT_IMPL(a_count_sat, clk, arst_n, 1'b1, count_q <= COUNT_W'(MAX_PACKET_BYTES))

endmodule
